@@ design/fic_pkg.sv @@
// Package for the frequent-items counter table: constants and shared types.
`timescale 1ns / 1ps
package fic_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int KEY_BITS_DEF  = 64;
  localparam int CNT_W         = 32;
  localparam int FRAC_W        = 16;
  localparam int RHS_W         = CNT_W + FRAC_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Shared control for every cell in the row
  typedef struct packed {
    logic rotate;   // shift the ring by one cell toward cell 0
    logic write;    // apply an update (hit increment or free-slot claim)
    logic dec_all;  // drop every nonzero count by one
  } cell_ctrl_t;

endpackage

@@ design/fic_cell.sv @@
// One counter slot: key and count, with compare, update and ring shift.
`timescale 1ns / 1ps
module fic_cell import fic_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic [KEY_BITS-1:0] bcast_key,
  input  logic                sel_hit,
  input  logic                sel_claim,
  input  logic [KEY_BITS-1:0] nb_key,
  input  logic [CNT_W-1:0]    nb_count,
  output logic [KEY_BITS-1:0] key_q,
  output logic [CNT_W-1:0]    count_q,
  output logic                hit
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign hit     = (count_r != '0) && (key_r == bcast_key);
  assign key_q   = key_r;
  assign count_q = count_r;

  // next state of the slot
  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    if (ctrl.rotate) begin
      key_nxt   = nb_key;
      count_nxt = nb_count;
    end else if (ctrl.write && sel_hit) begin
      if (count_r != CNT_MAX) count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.write && sel_claim) begin
      key_nxt   = bcast_key;
      count_nxt = CNT_W'(1);
    end else if (ctrl.dec_all && (count_r != '0)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // key holds no reset: only read while the count is nonzero
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

@@ design/frequent_items_counter_table_unit.sv @@
// An update is accepted only in idle; no new update or report is taken until its result beat is registered.
// A report walks the ring of cells one slot a cycle unless an output stall holds the walk, then gives
// its last beat; the ring ends back in its start order.
// Reset (rst_n low, synchronous) frees all slots, zeroes stream count and report_fraction.
// Config writes are taken in any cycle (cfg_ready tied high).
`timescale 1ns / 1ps
module frequent_items_counter_table_unit import fic_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FRAC_W-1:0]   cfg_report_fraction,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [KEY_BITS-1:0] in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KEY_BITS-1:0] out_key,
  output logic [CNT_W-1:0]    out_estimate,
  output logic                out_decremented,
  output logic                out_entry_valid,
  output logic                out_last
);

  localparam int SCW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [FRAC_W-1:0]   frac_r;
  logic [CNT_W-1:0]    stream_r, stream_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [RHS_W-1:0]    rhs_r;
  logic [SCW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [KEY_BITS-1:0] pend_key_r, pend_key_nxt;
  logic [CNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;

  logic                ov_r, ov_nxt;
  logic [KEY_BITS-1:0] okey_r, okey_nxt;
  logic [CNT_W-1:0]    oest_r, oest_nxt;
  logic                odec_r, odec_nxt, oev_r, oev_nxt, olast_r, olast_nxt;

  cell_ctrl_t          ctrl;
  logic [KEY_BITS-1:0] c_key [NUM_SLOTS];
  logic [CNT_W-1:0]    c_cnt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] hit_vec, free_vec, claim_vec;
  logic [CNT_W-1:0]    hit_cnt;
  logic                any_hit, any_free, head_q, out_can, accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_can   = !ov_r || out_ready;

  // cell ring: cell i takes from cell i+1, last takes from cell 0
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    fic_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .bcast_key (key_r),
      .sel_hit   (hit_vec[g]),
      .sel_claim (claim_vec[g]),
      .nb_key    (c_key[(g + 1) % NUM_SLOTS]),
      .nb_count  (c_cnt[(g + 1) % NUM_SLOTS]),
      .key_q     (c_key[g]),
      .count_q   (c_cnt[g]),
      .hit       (hit_vec[g])
    );
    assign free_vec[g] = (c_cnt[g] == '0);
  end

  // lowest free slot by two's complement isolate, only when the key is not held
  assign claim_vec = any_hit ? '0 : (free_vec & (~free_vec + NUM_SLOTS'(1)));
  assign any_hit   = |hit_vec;
  assign any_free  = |free_vec;

  // count of the hit slot (at most one held key matches)
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_cnt = hit_cnt | (c_cnt[i] & {CNT_W{hit_vec[i]}});
    end
  end

  assign head_q = (c_cnt[0] != '0) && ({c_cnt[0], {FRAC_W{1'b0}}} >= rhs_r);

  // control sequencer
  always_comb begin
    state_nxt    = state_r;
    stream_nxt   = stream_r;
    scan_cnt_nxt = scan_cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_key_nxt = pend_key_r;
    pend_cnt_nxt = pend_cnt_r;
    ctrl         = '0;
    ov_nxt       = ov_r && !out_ready;
    okey_nxt     = okey_r;
    oest_nxt     = oest_r;
    odec_nxt     = odec_r;
    oev_nxt      = oev_r;
    olast_nxt    = olast_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_cnt_nxt = '0;
          pend_v_nxt   = 1'b0;
          state_nxt    = (in_op == OP_REPORT) ? S_SCAN : S_UPD;
        end
      end
      S_UPD: begin
        if (out_can) begin
          if (stream_r != CNT_MAX) stream_nxt = stream_r + CNT_W'(1);
          ov_nxt    = 1'b1;
          okey_nxt  = key_r;
          olast_nxt = 1'b1;
          if (any_hit) begin
            ctrl.write = 1'b1;
            oest_nxt   = (hit_cnt != CNT_MAX) ? hit_cnt + CNT_W'(1) : hit_cnt;
            odec_nxt   = 1'b0;
            oev_nxt    = 1'b1;
          end else if (any_free) begin
            ctrl.write = 1'b1;
            oest_nxt   = CNT_W'(1);
            odec_nxt   = 1'b0;
            oev_nxt    = 1'b1;
          end else begin
            ctrl.dec_all = 1'b1;
            oest_nxt     = '0;
            odec_nxt     = 1'b1;
            oev_nxt      = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == SCW'(NUM_SLOTS)) begin
          state_nxt = S_DONE;
        end else if (!(head_q && pend_v_r && !out_can)) begin
          ctrl.rotate  = 1'b1;
          scan_cnt_nxt = scan_cnt_r + SCW'(1);
          if (head_q && pend_v_r) begin
            ov_nxt    = 1'b1;
            okey_nxt  = pend_key_r;
            oest_nxt  = pend_cnt_r;
            odec_nxt  = 1'b0;
            oev_nxt   = 1'b1;
            olast_nxt = 1'b0;
          end
          if (head_q) begin
            pend_v_nxt   = 1'b1;
            pend_key_nxt = c_key[0];
            pend_cnt_nxt = c_cnt[0];
          end
        end
      end
      S_DONE: begin
        if (out_can) begin
          ov_nxt    = 1'b1;
          okey_nxt  = pend_v_r ? pend_key_r : '0;
          oest_nxt  = pend_v_r ? pend_cnt_r : '0;
          odec_nxt  = 1'b0;
          oev_nxt   = pend_v_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      frac_r     <= '0;
      stream_r   <= '0;
      scan_cnt_r <= '0;
      pend_v_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      stream_r   <= stream_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      ov_r       <= ov_nxt;
      if (cfg_valid && cfg_ready) frac_r <= cfg_report_fraction;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_key;
      rhs_r <= RHS_W'(frac_r) * RHS_W'(stream_r);
    end
    pend_key_r <= pend_key_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    okey_r     <= okey_nxt;
    oest_r     <= oest_nxt;
    odec_r     <= odec_nxt;
    oev_r      <= oev_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_key         = okey_r;
  assign out_estimate    = oest_r;
  assign out_decremented = odec_r;
  assign out_entry_valid = oev_r;
  assign out_last        = olast_r;

endmodule

@@ design/fic_checker.sv @@
// Port-level checks for the frequent-items counter table, bound to the top level.
`timescale 1ns / 1ps
module fic_checker import fic_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KEY_BITS-1:0] out_key,
  input logic [CNT_W-1:0]    out_estimate,
  input logic                out_decremented,
  input logic                out_entry_valid,
  input logic                out_last
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_estimate))
    else $error("result beat changed while stalled");

  // a beat naming no entry carries zero estimate and closes the item
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_estimate == '0 && out_last)
    else $error("empty beat malformed");

  // a decrement beat names no held entry and closes the item
  a_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decremented |-> !out_entry_valid && out_last)
    else $error("decrement beat malformed");

  // a held entry has a nonzero count
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_estimate != '0 && !out_decremented)
    else $error("held entry with zero count");

endmodule

bind frequent_items_counter_table_unit fic_checker #(.KEY_BITS(KEY_BITS)) u_fic_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_key         (out_key),
  .out_estimate    (out_estimate),
  .out_decremented (out_decremented),
  .out_entry_valid (out_entry_valid),
  .out_last        (out_last)
);
